// ===== hw/rtl/mandelbrot_escape_pixel_unit_assert.svh =====
// Assertion macros used by mep_ctrl.
`ifndef MANDELBROT_ESCAPE_PIXEL_UNIT_ASSERT_SVH
`define MANDELBROT_ESCAPE_PIXEL_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MEP_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("mep assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define MEP_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("mep assertion failed");

`endif

// ===== hw/rtl/mep_pkg.sv =====
package mep_pkg;

  localparam int ColW   = 8;
  localparam int RowW   = 7;
  localparam int IterW  = 10;
  localparam int StepW  = 31;
  localparam int DataW  = 32;
  localparam int ApbAw  = 4;
  localparam int RowsDflt = 128;

  localparam longint SpanQ = 64'sd644245094;
  localparam logic signed [31:0] XOrgRst = -32'sd536870912;
  localparam logic signed [31:0] YOrgRst = -32'sd322122547;
  localparam logic [IterW-1:0] MaxIterRst = 10'd100;
  localparam logic [63:0] EscLimit = 64'h0400_0000_0000_0000;

  typedef enum logic [1:0] {
    REG_X_ORIGIN = 2'd0,
    REG_Y_ORIGIN = 2'd1,
    REG_STEP     = 2'd2,
    REG_MAX_ITER = 2'd3
  } mep_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COORD,
    ST_MUL,
    ST_UPD,
    ST_EMIT
  } mep_state_e;

  typedef struct packed {
    logic signed [31:0] x_origin;
    logic signed [31:0] y_origin;
    logic [StepW-1:0]   step;
    logic [IterW-1:0]   max_iter;
  } mep_cfg_t;

  typedef struct packed {
    logic load;
    logic coord;
    logic mul;
    logic upd;
    logic emit;
  } mep_cmd_t;

  typedef struct packed {
    logic done;
  } mep_sts_t;

  function automatic logic signed [31:0] sat32(input logic signed [40:0] v);
    if (v > 41'sd2147483647) begin
      return 32'sh7FFF_FFFF;
    end else if (v < -41'sd2147483648) begin
      return 32'sh8000_0000;
    end else begin
      return v[31:0];
    end
  endfunction

endpackage

// ===== hw/rtl/mep_if.sv =====
interface mep_pix_if;
  import mep_pkg::*;

  logic            valid;
  logic            ready;
  logic [ColW-1:0] col;
  logic [RowW-1:0] row;

  modport source (output valid, output col, output row, input ready);
  modport sink (input valid, input col, input row, output ready);
endinterface

interface mep_res_if;
  import mep_pkg::*;

  logic             valid;
  logic             ready;
  logic [ColW-1:0]  col_out;
  logic [RowW-1:0]  row_out;
  logic             in_set;
  logic [IterW-1:0] iterations;

  modport source (output valid, output col_out, output row_out, output in_set,
                  output iterations, input ready);
  modport sink (input valid, input col_out, input row_out, input in_set,
                input iterations, output ready);
endinterface

// ===== hw/rtl/mep_regs.sv =====
module mep_regs #(
  parameter int ROWS = mep_pkg::RowsDflt
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mep_pkg::ApbAw-1:0]   paddr,
  input  logic [mep_pkg::DataW-1:0]   pwdata,
  output logic [mep_pkg::DataW-1:0]   prdata,
  output logic                        pready,
  output mep_pkg::mep_cfg_t           cfg_o
);
  import mep_pkg::*;

  localparam longint StepRst = (SpanQ + ROWS / 2) / ROWS;

  mep_cfg_t cfg_q, cfg_d;
  mep_reg_e sel;
  logic     wr;

  assign sel    = mep_reg_e'(paddr[3:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr) begin
      unique case (sel)
        REG_X_ORIGIN: cfg_d.x_origin = pwdata;
        REG_Y_ORIGIN: cfg_d.y_origin = pwdata;
        REG_STEP:     cfg_d.step     = pwdata[StepW-1:0];
        REG_MAX_ITER: cfg_d.max_iter = pwdata[IterW-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      REG_X_ORIGIN: prdata = cfg_q.x_origin;
      REG_Y_ORIGIN: prdata = cfg_q.y_origin;
      REG_STEP:     prdata = {{(DataW-StepW){1'b0}}, cfg_q.step};
      REG_MAX_ITER: prdata = {{(DataW-IterW){1'b0}}, cfg_q.max_iter};
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.x_origin <= XOrgRst;
      cfg_q.y_origin <= YOrgRst;
      cfg_q.step     <= StepRst[StepW-1:0];
      cfg_q.max_iter <= MaxIterRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ===== hw/rtl/mep_ctrl.sv =====
`include "mandelbrot_escape_pixel_unit_assert.svh"

module mep_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  mep_pkg::mep_sts_t sts_i,
  output mep_pkg::mep_cmd_t cmd_o
);
  import mep_pkg::*;

  mep_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = ST_COORD;
      ST_COORD: state_d = ST_MUL;
      ST_MUL:   state_d = ST_UPD;
      ST_UPD:   state_d = sts_i.done ? ST_EMIT : ST_MUL;
      ST_EMIT:  if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o  = (state_q == ST_IDLE);
    cmd_o.load  = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.coord = (state_q == ST_COORD);
    cmd_o.mul   = (state_q == ST_MUL);
    cmd_o.upd   = (state_q == ST_UPD) && !sts_i.done;
    cmd_o.emit  = (state_q == ST_EMIT) && out_free;
    out_valid_d = cmd_o.emit ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  `MEP_ASSERT_NEXT(a_accept_starts, clk_i, rst_ni, in_valid_i && in_ready_o, state_q == ST_COORD)
  `MEP_ASSERT_NOW(a_emit_slot_free, clk_i, rst_ni, cmd_o.emit, !out_valid_q || out_ready_i)
  `MEP_ASSERT_NEXT(a_loop_back, clk_i, rst_ni, cmd_o.upd, state_q == ST_MUL)
  `MEP_ASSERT_NEXT(a_emit_shows, clk_i, rst_ni, cmd_o.emit, out_valid_q && state_q == ST_IDLE)

endmodule

// ===== hw/rtl/mep_dp.sv =====
module mep_dp (
  input  logic                        clk_i,
  input  mep_pkg::mep_cfg_t           cfg_i,
  input  mep_pkg::mep_cmd_t           cmd_i,
  output mep_pkg::mep_sts_t           sts_o,
  input  logic [mep_pkg::ColW-1:0]    col_i,
  input  logic [mep_pkg::RowW-1:0]    row_i,
  output logic [mep_pkg::ColW-1:0]    col_out_o,
  output logic [mep_pkg::RowW-1:0]    row_out_o,
  output logic                        in_set_o,
  output logic [mep_pkg::IterW-1:0]   iterations_o
);
  import mep_pkg::*;

  logic [ColW-1:0]    col_q, res_col_q;
  logic [RowW-1:0]    row_q, res_row_q;
  logic signed [31:0] cr_q, ci_q, x_q, y_q;
  logic signed [63:0] xx_q, yy_q, xy_q;
  logic [IterW-1:0]   iter_q, res_iter_q;
  logic               res_in_set_q;

  logic [38:0]        prod_x, prod_y;
  logic signed [40:0] cx_sum, cy_sum, nx_sum, ny_sum;
  logic signed [63:0] diff;
  logic [63:0]        mag;
  logic               escaped;

  assign prod_x = 39'(col_q) * 39'(cfg_i.step);
  assign prod_y = 39'(row_q) * 39'(cfg_i.step);
  assign cx_sum = $signed({{9{cfg_i.x_origin[31]}}, cfg_i.x_origin}) + $signed({2'b00, prod_x});
  assign cy_sum = $signed({{9{cfg_i.y_origin[31]}}, cfg_i.y_origin}) + $signed({2'b00, prod_y});

  assign diff   = xx_q - yy_q;
  assign nx_sum = $signed({{5{diff[63]}}, diff[63:28]}) + $signed({{9{cr_q[31]}}, cr_q});
  assign ny_sum = $signed({{4{xy_q[63]}}, xy_q[63:27]}) + $signed({{9{ci_q[31]}}, ci_q});

  assign mag     = $unsigned(xx_q) + $unsigned(yy_q);
  assign escaped = (mag > EscLimit);
  assign sts_o.done = escaped || (iter_q == cfg_i.max_iter);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      col_q <= col_i;
      row_q <= row_i;
    end
    if (cmd_i.coord) begin
      cr_q   <= sat32(cx_sum);
      ci_q   <= sat32(cy_sum);
      x_q    <= '0;
      y_q    <= '0;
      iter_q <= '0;
    end
    if (cmd_i.mul) begin
      xx_q <= 64'(x_q) * 64'(x_q);
      yy_q <= 64'(y_q) * 64'(y_q);
      xy_q <= 64'(x_q) * 64'(y_q);
    end
    if (cmd_i.upd) begin
      x_q    <= sat32(nx_sum);
      y_q    <= sat32(ny_sum);
      iter_q <= iter_q + 1'b1;
    end
    if (cmd_i.emit) begin
      res_col_q    <= col_q;
      res_row_q    <= row_q;
      res_in_set_q <= !escaped;
      res_iter_q   <= escaped ? iter_q - 1'b1 : iter_q;
    end
  end

  assign col_out_o    = res_col_q;
  assign row_out_o    = res_row_q;
  assign in_set_o     = res_in_set_q;
  assign iterations_o = res_iter_q;

endmodule

// ===== hw/rtl/mandelbrot_escape_pixel_unit.sv =====
// Channel   Dir  Payload                               Handshake
// pix_i     in   col, row                              valid/ready
// res_o     out  col_out, row_out, in_set, iterations  valid/ready
// APB       in   x_origin, y_origin, step, max_iter    psel/penable, pready high
//
// A pixel runs passes until it escapes or max_iter updates are done; each
// pass is a multiply step followed by an update step, skipped on the last.
// The multiply step forms the three 32x32 products of the current point.
// Reset clears the controller and loads the register defaults.
// A finished transaction waits in the output register; a new pixel is taken
// meanwhile and stalls only at its own result until the register is free.
module mandelbrot_escape_pixel_unit #(
  parameter int ROWS = mep_pkg::RowsDflt
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  mep_pix_if.sink                   pix_i,
  mep_res_if.source                 res_o,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [mep_pkg::ApbAw-1:0] paddr,
  input  logic [mep_pkg::DataW-1:0] pwdata,
  output logic [mep_pkg::DataW-1:0] prdata,
  output logic                      pready
);
  import mep_pkg::*;

  mep_cfg_t cfg;
  mep_cmd_t cmd;
  mep_sts_t sts;

  mep_regs #(
    .ROWS(ROWS)
  ) u_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg_o  (cfg)
  );

  mep_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (pix_i.valid),
    .in_ready_o (pix_i.ready),
    .out_valid_o(res_o.valid),
    .out_ready_i(res_o.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mep_dp u_dp (
    .clk_i       (clk_i),
    .cfg_i       (cfg),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .col_i       (pix_i.col),
    .row_i       (pix_i.row),
    .col_out_o   (res_o.col_out),
    .row_out_o   (res_o.row_out),
    .in_set_o    (res_o.in_set),
    .iterations_o(res_o.iterations)
  );

endmodule
